/* rtl/ncsg_pkg.sv */
// Shared types and constants for the column statistics and GCD block.
`timescale 1ns / 1ps

package ncsg_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned CountW = 32;
  localparam int unsigned WidthW = 7;
  localparam int unsigned SubW   = ValueW + 1;
  localparam int unsigned StepW  = $clog2(ValueW);

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic [ValueW-1:0] min_value;
    logic [ValueW-1:0] common_divisor;
    logic [WidthW-1:0] bit_width;
    logic [CountW-1:0] value_count;
  } out_word_t;

  // Operands and result of the shared subtractor.
  typedef struct packed {
    logic [SubW-1:0] a;
    logic [SubW-1:0] b;
  } sub_op_t;

  typedef struct packed {
    logic [SubW-1:0] diff;
    logic            borrow;
  } sub_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIN,
    ST_MAX,
    ST_DIFF,
    ST_NEG,
    ST_GSETUP,
    ST_GTWO,
    ST_GRED,
    ST_CHK,
    ST_RANGE,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

/* rtl/ncsg_sub_unit.sv */
// Shared 65-bit subtractor with borrow, used for compares, distances, GCD and division.
`timescale 1ns / 1ps

module ncsg_sub_unit (
  input  ncsg_pkg::sub_op_t  op_i,
  output ncsg_pkg::sub_res_t res_o
);

  logic [ncsg_pkg::SubW:0] full;

  assign full         = {1'b0, op_i.a} - {1'b0, op_i.b};
  assign res_o.diff   = full[ncsg_pkg::SubW-1:0];
  assign res_o.borrow = full[ncsg_pkg::SubW];

endmodule

/* rtl/numeric_column_stats_gcd_top.sv */
// Top level: run statistics, binary GCD and packing width, all on one shared subtractor.
// A first word goes straight to the check; a later word passes the min, max and distance
// steps and then the binary GCD.
// A last word adds the range step, plus a restoring division when the run is not constant.
// One word is in work at a time; the result register lets a new word start while it waits.
// Reset is asynchronous and active low; it clears the sequencer, the run flags and the output valid flag.
`timescale 1ns / 1ps

module numeric_column_stats_gcd_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ncsg_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ncsg_pkg::out_word_t  out_data_o
);

  localparam int unsigned VW = ncsg_pkg::ValueW;
  localparam int unsigned CW = ncsg_pkg::CountW;
  localparam int unsigned WW = ncsg_pkg::WidthW;
  localparam int unsigned SW = ncsg_pkg::StepW;

  ncsg_pkg::state_e state_q, state_d;

  logic          first_seen_q, first_seen_d;
  logic          too_large_q, too_large_d;
  logic          last_q, last_d;
  logic [VW-1:0] val_q, val_d;
  logic [VW-1:0] first_q, first_d;
  logic [VW-1:0] min_q, min_d;
  logic [VW-1:0] max_q, max_d;
  logic [VW-1:0] gcd_q, gcd_d;
  logic [CW-1:0] count_q, count_d;
  logic [VW-1:0] ga_q, ga_d;
  logic [VW-1:0] gb_q, gb_d;
  logic [SW-1:0] k_q, k_d;
  logic [VW-1:0] div_q, div_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] nq_q, nq_d;
  logic [SW-1:0] step_q, step_d;
  logic [WW-1:0] width_q, width_d;

  ncsg_pkg::out_word_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  ncsg_pkg::sub_op_t  sub_op;
  ncsg_pkg::sub_res_t sub_res;

  logic accept;
  logic out_free;

  ncsg_sub_unit u_sub (
    .op_i  (sub_op),
    .res_o (sub_res)
  );

  assign in_ready_o  = (state_q == ncsg_pkg::ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Operand selection for the shared subtractor.
  always_comb begin
    sub_op.a = '0;
    sub_op.b = '0;
    unique case (state_q)
      ncsg_pkg::ST_MIN: begin
        sub_op.a = {1'b0, val_q};
        sub_op.b = {1'b0, min_q};
      end
      ncsg_pkg::ST_MAX: begin
        sub_op.a = {1'b0, max_q};
        sub_op.b = {1'b0, val_q};
      end
      ncsg_pkg::ST_DIFF: begin
        sub_op.a = {1'b0, val_q};
        sub_op.b = {1'b0, first_q};
      end
      ncsg_pkg::ST_NEG: begin
        sub_op.a = {1'b0, first_q};
        sub_op.b = {1'b0, val_q};
      end
      ncsg_pkg::ST_GRED: begin
        sub_op.a = {1'b0, gb_q};
        sub_op.b = {1'b0, ga_q};
      end
      ncsg_pkg::ST_RANGE: begin
        sub_op.a = {1'b0, max_q};
        sub_op.b = {1'b0, min_q};
      end
      ncsg_pkg::ST_DIV: begin
        sub_op.a = {rem_q, nq_q[VW-1]};
        sub_op.b = {1'b0, div_q};
      end
      default: begin
        sub_op.a = '0;
        sub_op.b = '0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ncsg_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = first_seen_q ? ncsg_pkg::ST_MIN : ncsg_pkg::ST_CHK;
        end
      end
      ncsg_pkg::ST_MIN:  state_d = ncsg_pkg::ST_MAX;
      ncsg_pkg::ST_MAX:  state_d = ncsg_pkg::ST_DIFF;
      ncsg_pkg::ST_DIFF: begin
        state_d = sub_res.borrow ? ncsg_pkg::ST_NEG : ncsg_pkg::ST_GSETUP;
      end
      ncsg_pkg::ST_NEG:  state_d = ncsg_pkg::ST_GSETUP;
      ncsg_pkg::ST_GSETUP: begin
        if ((ga_q == '0) || (gb_q == '0)) begin
          state_d = ncsg_pkg::ST_CHK;
        end else begin
          state_d = ncsg_pkg::ST_GTWO;
        end
      end
      ncsg_pkg::ST_GTWO: begin
        if (ga_q[0] || gb_q[0]) begin
          state_d = ncsg_pkg::ST_GRED;
        end
      end
      ncsg_pkg::ST_GRED: begin
        if (gb_q == '0) begin
          state_d = ncsg_pkg::ST_CHK;
        end
      end
      ncsg_pkg::ST_CHK: begin
        state_d = last_q ? ncsg_pkg::ST_RANGE : ncsg_pkg::ST_IDLE;
      end
      ncsg_pkg::ST_RANGE: begin
        if (sub_res.diff[VW-1:0] == '0) begin
          state_d = ncsg_pkg::ST_DONE;
        end else begin
          state_d = ncsg_pkg::ST_DIV;
        end
      end
      ncsg_pkg::ST_DIV: begin
        if (step_q == SW'(VW - 1)) begin
          state_d = ncsg_pkg::ST_DONE;
        end
      end
      ncsg_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = ncsg_pkg::ST_IDLE;
        end
      end
      default: state_d = ncsg_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates per state.
  always_comb begin
    first_seen_d = first_seen_q;
    too_large_d  = too_large_q;
    last_d       = last_q;
    val_d        = val_q;
    first_d      = first_q;
    min_d        = min_q;
    max_d        = max_q;
    gcd_d        = gcd_q;
    count_d      = count_q;
    ga_d         = ga_q;
    gb_d         = gb_q;
    k_d          = k_q;
    div_d        = div_q;
    rem_d        = rem_q;
    nq_d         = nq_q;
    step_d       = step_q;
    width_d      = width_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    unique case (state_q)
      ncsg_pkg::ST_IDLE: begin
        if (accept) begin
          val_d  = in_data_i.value;
          last_d = in_data_i.last;
          if (!first_seen_q) begin
            first_seen_d = 1'b1;
            first_d      = in_data_i.value;
            min_d        = in_data_i.value;
            max_d        = in_data_i.value;
            gcd_d        = '0;
            count_d      = CW'(1);
            too_large_d  = in_data_i.value[VW-1];
          end else begin
            if (count_q != '1) begin
              count_d = count_q + CW'(1);
            end
            too_large_d = too_large_q || in_data_i.value[VW-1];
          end
        end
      end
      ncsg_pkg::ST_MIN: begin
        if (sub_res.borrow) begin
          min_d = val_q;
        end
      end
      ncsg_pkg::ST_MAX: begin
        if (sub_res.borrow) begin
          max_d = val_q;
        end
      end
      ncsg_pkg::ST_DIFF: begin
        ga_d = gcd_q;
        gb_d = sub_res.diff[VW-1:0];
      end
      ncsg_pkg::ST_NEG: begin
        gb_d = sub_res.diff[VW-1:0];
      end
      ncsg_pkg::ST_GSETUP: begin
        k_d = '0;
        if (ga_q == '0) begin
          gcd_d = gb_q;
        end else if (gb_q == '0) begin
          gcd_d = ga_q;
        end
      end
      ncsg_pkg::ST_GTWO: begin
        // Strip the common power of two, remembered in k.
        if (!ga_q[0] && !gb_q[0]) begin
          ga_d = ga_q >> 1;
          gb_d = gb_q >> 1;
          k_d  = k_q + SW'(1);
        end
      end
      ncsg_pkg::ST_GRED: begin
        // Keep both odd, then subtract the smaller from the larger until one is zero.
        if (gb_q == '0) begin
          gcd_d = ga_q << k_q;
        end else if (!ga_q[0]) begin
          ga_d = ga_q >> 1;
        end else if (!gb_q[0]) begin
          gb_d = gb_q >> 1;
        end else if (sub_res.borrow) begin
          ga_d = gb_q;
          gb_d = ga_q;
        end else begin
          gb_d = sub_res.diff[VW-1:0];
        end
      end
      ncsg_pkg::ST_RANGE: begin
        nq_d    = sub_res.diff[VW-1:0];
        rem_d   = '0;
        step_d  = '0;
        width_d = '0;
        if ((sub_res.diff[VW-1:0] == '0) || too_large_q || (gcd_q == '0)) begin
          div_d = VW'(1);
        end else begin
          div_d = gcd_q;
        end
      end
      ncsg_pkg::ST_DIV: begin
        // Restoring division; the first quotient one sets the width.
        if (!sub_res.borrow) begin
          rem_d = sub_res.diff[VW-1:0];
          if (width_q == '0) begin
            width_d = WW'(VW) - {1'b0, step_q};
          end
        end else begin
          rem_d = sub_op.a[VW-1:0];
        end
        nq_d   = nq_q << 1;
        step_d = step_q + SW'(1);
      end
      ncsg_pkg::ST_DONE: begin
        if (out_free) begin
          out_d.min_value      = min_q;
          out_d.common_divisor = div_q;
          out_d.bit_width      = width_q;
          out_d.value_count    = count_q;
          out_valid_d          = 1'b1;
          first_seen_d         = 1'b0;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ncsg_pkg::ST_IDLE;
      first_seen_q <= 1'b0;
      too_large_q  <= 1'b0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      k_q          <= '0;
      step_q       <= '0;
      width_q      <= '0;
    end else begin
      state_q      <= state_d;
      first_seen_q <= first_seen_d;
      too_large_q  <= too_large_d;
      last_q       <= last_d;
      out_valid_q  <= out_valid_d;
      k_q          <= k_d;
      step_q       <= step_d;
      width_q      <= width_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    first_q <= first_d;
    min_q   <= min_d;
    max_q   <= max_d;
    gcd_q   <= gcd_d;
    count_q <= count_d;
    ga_q    <= ga_d;
    gb_q    <= gb_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    nq_q    <= nq_d;
    out_q   <= out_d;
  end

endmodule

/* rtl/ncsg_checker.sv */
// Port-level checker for the column statistics block, bound to the top level.
`timescale 1ns / 1ps

module ncsg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input ncsg_pkg::in_word_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ncsg_pkg::out_word_t out_data_o
);

  // A result word that is not taken stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // Taking a word makes the block busy, so ready drops.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a word was taken");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.common_divisor != '0 && out_data_o.value_count != '0)
    else $error("zero divisor or zero count in result");

  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.bit_width <= ncsg_pkg::WidthW'(ncsg_pkg::ValueW))
    else $error("bit width out of range");

  // A constant run reports divisor one.
  a_const_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bit_width == '0 |-> out_data_o.common_divisor == 64'd1)
    else $error("zero width with divisor other than one");

endmodule

bind numeric_column_stats_gcd_top ncsg_checker u_ncsg_checker (.*);

/* tb/sv/numeric_column_stats_gcd_top_tb.sv */
// Self-checking testbench for the column statistics and GCD block.
`timescale 1ns / 1ps

module numeric_column_stats_gcd_top_tb;

  localparam int unsigned VW = ncsg_pkg::ValueW;
  localparam int unsigned CW = ncsg_pkg::CountW;
  localparam int unsigned WW = ncsg_pkg::WidthW;

  localparam logic [VW-1:0] SignedMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [CW-1:0] CountSat  = '1;
  localparam int unsigned LongStall = 3000;
  localparam int unsigned TailCycles = 400;
  localparam int unsigned MaxPrinted = 100;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  ncsg_pkg::in_word_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  ncsg_pkg::out_word_t out_data_o;

  numeric_column_stats_gcd_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Words waiting to be offered and run summaries waiting to come out.
  ncsg_pkg::in_word_t  queued_words[$];
  ncsg_pkg::out_word_t pending_summaries[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_req = 0;
  int unsigned stall_ack = 0;
  int unsigned stall_left = 0;

  int unsigned n_errors = 0;
  int unsigned n_queued = 0;
  int unsigned n_words = 0;
  int unsigned n_runs = 0;
  int unsigned n_forced = 0;
  int unsigned n_flat = 0;
  int unsigned n_checked = 0;

  // Shadow of the run statistics.
  logic          run_open = 1'b0;
  logic [VW-1:0] run_first = '0;
  logic [VW-1:0] run_lo = '0;
  logic [VW-1:0] run_hi = '0;
  logic [VW-1:0] run_div = '0;
  logic [CW-1:0] run_cnt = '0;
  logic          run_big = 1'b0;

  task automatic note_mismatch(input string msg);
    if (n_errors < MaxPrinted) $display("ERROR at %0t: %s", $time, msg);
    n_errors++;
  endtask

  function automatic logic [VW-1:0] euclid_gcd(input logic [VW-1:0] a,
                                               input logic [VW-1:0] b);
    logic [VW-1:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic logic [WW-1:0] span_bits(input logic [VW-1:0] n);
    logic [WW-1:0] w;
    w = '0;
    while (n != 0) begin
      w++;
      n = n >> 1;
    end
    return w;
  endfunction

  // Folds one accepted word into the shadow run and, on the last word, queues the summary.
  function automatic void fold_word(input ncsg_pkg::in_word_t w);
    logic [VW-1:0] gap;
    logic [VW-1:0] div;
    ncsg_pkg::out_word_t r;
    n_words++;
    if (!run_open) begin
      run_open  = 1'b1;
      run_first = w.value;
      run_lo    = w.value;
      run_hi    = w.value;
      run_div   = '0;
      run_cnt   = CW'(1);
      run_big   = w.value > SignedMax;
    end else begin
      gap = (w.value >= run_first) ? w.value - run_first : run_first - w.value;
      if (w.value < run_lo) run_lo = w.value;
      if (w.value > run_hi) run_hi = w.value;
      run_div = euclid_gcd(run_div, gap);
      if (run_cnt != CountSat) run_cnt++;
      if (w.value > SignedMax) run_big = 1'b1;
    end
    if (w.last) begin
      div = VW'(1);
      r.bit_width = '0;
      if (run_hi != run_lo) begin
        if (!run_big && run_div != 0) div = run_div;
        r.bit_width = span_bits((run_hi - run_lo) / div);
      end else begin
        n_flat++;
      end
      if (run_big) n_forced++;
      r.min_value      = run_lo;
      r.common_divisor = div;
      r.value_count    = run_cnt;
      pending_summaries.insert(pending_summaries.size(), r);
      n_runs++;
      run_open  = 1'b0;
      run_first = '0;
      run_lo    = '0;
      run_hi    = '0;
      run_div   = '0;
      run_cnt   = '0;
      run_big   = 1'b0;
    end
  endfunction

  // Sender: holds a word until it is taken, otherwise offers the next one or idles.
  always @(posedge clk_i) begin : drive_words
    logic taken;
    logic busy;
    taken = in_valid_i && in_ready_o;
    if (taken) fold_word(in_data_i);
    busy = in_valid_i && !taken;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!busy) begin
      if (queued_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data_i  <= queued_words.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: a requested long hold-off takes priority over random idling.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_req != stall_ack) begin
      stall_ack   <= stall_ack + 1;
      stall_left  <= LongStall;
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_summaries
    ncsg_pkg::out_word_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_summaries.size() == 0) begin
        note_mismatch("result word with no run summary expected");
      end else begin
        exp_r = pending_summaries.pop_front();
        n_checked++;
        if (out_data_o.min_value !== exp_r.min_value)
          note_mismatch($sformatf("run %0d min_value %h, expected %h", n_checked,
                                  out_data_o.min_value, exp_r.min_value));
        if (out_data_o.common_divisor !== exp_r.common_divisor)
          note_mismatch($sformatf("run %0d common_divisor %h, expected %h", n_checked,
                                  out_data_o.common_divisor, exp_r.common_divisor));
        if (out_data_o.bit_width !== exp_r.bit_width)
          note_mismatch($sformatf("run %0d bit_width %0d, expected %0d", n_checked,
                                  out_data_o.bit_width, exp_r.bit_width));
        if (out_data_o.value_count !== exp_r.value_count)
          note_mismatch($sformatf("run %0d value_count %0d, expected %0d", n_checked,
                                  out_data_o.value_count, exp_r.value_count));
      end
    end
  end

  function automatic logic [VW-1:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  task automatic push_word(input logic [VW-1:0] v, input logic is_last);
    ncsg_pkg::in_word_t w;
    w.value = v;
    w.last  = is_last;
    queued_words.insert(queued_words.size(), w);
    n_queued++;
  endtask

  // One run of random length whose values follow one of several patterns.
  task automatic queue_random_run();
    int unsigned len;
    int unsigned style;
    int unsigned k;
    logic [VW-1:0] base;
    logic [VW-1:0] stride;
    logic [VW-1:0] v;
    len   = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
    style = $urandom_range(9);
    base  = rand_value();
    base[VW-1 -: 3] = 3'b001;
    case ($urandom_range(2))
      0: stride = VW'($urandom_range(1000, 1));
      1: stride = 64'd1 << $urandom_range(40);
      default: stride = {32'b0, $urandom};
    endcase
    if (style == 7) base = rand_value();
    for (int i = 0; i < len; i++) begin
      case (style)
        0, 1: v = rand_value();
        2, 3, 4: begin
          k = $urandom_range(255);
          v = $urandom_range(1) ? base + k * stride : base - k * stride;
        end
        5: v = VW'($urandom_range(15));
        6: v = SignedMax - 2 + VW'($urandom_range(4));
        7: v = base;
        8: begin
          if ($urandom_range(3) == 0) v = $urandom_range(1) ? '0 : '1;
          else v = rand_value() >> 1;
        end
        default: begin
          v = rand_value();
          v[VW-1] = 1'b1;
        end
      endcase
      push_word(v, i == len - 1);
    end
  endtask

  task automatic queue_random_items(input int unsigned target);
    int unsigned start;
    start = n_queued;
    while (n_queued - start < target) queue_random_run();
  endtask

  // The test sequence pauses here until every queued word is taken and every summary has come out.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (queued_words.size() != 0 || in_valid_i || pending_summaries.size() != 0);
  endtask

  initial begin
    send_idle_pct = 19;
    recv_idle_pct = 73;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Single-word runs at both ends of the range.
    push_word('0, 1'b1);
    push_word('1, 1'b1);
    // Constant run.
    push_word(64'd5, 1'b0);
    push_word(64'd5, 1'b0);
    push_word(64'd5, 1'b1);
    // Distances 60 and 30 from the first value give a divisor of 30.
    push_word(64'd100, 1'b0);
    push_word(64'd40, 1'b0);
    push_word(64'd70, 1'b1);
    // Largest value that does not force the divisor.
    push_word('0, 1'b0);
    push_word(SignedMax, 1'b1);
    // A value above the signed range forces the divisor to one.
    push_word(64'd10, 1'b0);
    push_word(SignedMax + 1, 1'b0);
    push_word(64'd20, 1'b1);
    // Full 64-bit span.
    push_word('0, 1'b0);
    push_word('1, 1'b1);
    // Minimum in the middle of the run.
    push_word(64'd7, 1'b0);
    push_word(64'd3, 1'b0);
    push_word(64'd19, 1'b0);
    push_word(64'd11, 1'b1);
    // Both values just around the signed limit.
    push_word(SignedMax, 1'b0);
    push_word(SignedMax + 1, 1'b1);

    queue_random_items(480);
    wait_drained();

    send_idle_pct = 73;
    recv_idle_pct = 19;
    queue_random_items(480);
    wait_drained();

    // Long output stall while single-word runs keep arriving, so the input backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req = stall_req + 1;
    for (int i = 0; i < 30; i++) push_word(rand_value() >> $urandom_range(63), 1'b1);
    wait_drained();

    queue_random_items(440);
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d words in %0d runs: %0d constant, %0d with a value above 2^63-1.",
             n_words, n_runs, n_flat, n_forced);
    $display("Both idling mixes, a %0d-cycle output stall and drained pauses were exercised.",
             LongStall);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timed out with %0d words queued and %0d summaries outstanding.",
             queued_words.size(), pending_summaries.size());
    $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/ncsg_pkg.sv
rtl/ncsg_sub_unit.sv
rtl/numeric_column_stats_gcd_top.sv
rtl/ncsg_checker.sv
tb/sv/numeric_column_stats_gcd_top_tb.sv
